/* sv/siim_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siim_pkg: shared types for the sorted interval insert/merge core
// Interval record and result record used by the core and its output stage.
// ----------------------------------------------------------------------------
package siim_pkg;

  localparam int unsigned VAL_W = 32;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_INSERT = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] start;
    logic signed [VAL_W-1:0] stop;
  } ival_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] start;
    logic signed [VAL_W-1:0] stop;
    logic                    last;
    logic                    ovf;
  } rsp_t;

endpackage

/* sv/siim_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siim_req_if: request channel
// Valid/ready channel carrying one append or insert request.
// ----------------------------------------------------------------------------
interface siim_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] new_start;
  logic signed [31:0] new_stop;

  modport source (output valid, output req_type, output new_start, output new_stop,
                  input ready);
  modport sink   (input valid, input req_type, input new_start, input new_stop,
                  output ready);
endinterface

/* sv/siim_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siim_rsp_if: result channel
// Valid/ready channel carrying one interval of the merged table.
// ----------------------------------------------------------------------------
interface siim_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_start;
  logic signed [31:0] out_stop;
  logic               is_last;
  logic               overflow;

  modport source (output valid, output out_start, output out_stop, output is_last,
                  output overflow, input ready);
  modport sink   (input valid, input out_start, input out_stop, input is_last,
                  input overflow, output ready);
endinterface

/* sv/siim_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siim_out_buf: result output register
// Holds one result until the sink takes it; free whenever a new one may load.
// ----------------------------------------------------------------------------
module siim_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  siim_pkg::rsp_t  item,
  output logic            free,
  siim_rsp_if.source      rsp
);
  import siim_pkg::*;

  logic valid;
  rsp_t data;

  assign free = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= item;
    end
  end

  assign rsp.valid     = valid;
  assign rsp.out_start = data.start;
  assign rsp.out_stop  = data.stop;
  assign rsp.is_last   = data.last;
  assign rsp.overflow  = data.ovf;

endmodule

/* sv/sorted_interval_insert_merge_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_interval_insert_merge_core: interval table with insert and merge
// Interval table in a single-port-read memory, rewritten in place on insert.
// ----------------------------------------------------------------------------
// An append request writes its interval at the end of the table. On an insert
// request the table memory is walked one entry per cycle through its one read
// port, as long as the output register is free; the new interval is slotted in
// ahead of the first larger start, and each merged interval is written back and
// sent out as soon as it closes, the last one with is_last set. An insert into a
// full table returns a single overflow result. Requests are taken only between
// walks; a pending result in the output register does not hold off the next
// request.
module sorted_interval_insert_merge_core #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  siim_req_if.sink   req,
  siim_rsp_if.source rsp
);
  import siim_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MERGE = 3'b010,
    S_OVF   = 3'b100
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  count;     // stored intervals
  logic [CW-1:0]  cons;      // stored entries consumed by the walk
  logic [CW-1:0]  w;         // write-back index of the open interval
  logic           placed;
  logic           have_cur;
  logic           dvalid;    // rd_data holds entry cons
  ival_t          cur;
  ival_t          nreq;

  ival_t          mem [TABLE_DEPTH];
  ival_t          rd_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  ival_t          wr_data;

  logic           ob_free;
  logic           ob_load;
  rsp_t           ob_item;

  logic           acc;
  logic           acc_app;
  logic           acc_ins;
  logic           full;
  logic           step;
  logic           take_new;
  logic           take_old;
  logic           finish;
  logic           close;
  ival_t          elem;
  logic [CW-1:0]  cons_inc;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign acc_app   = acc && (req.req_type == REQ_APPEND);
  assign acc_ins   = acc && (req.req_type == REQ_INSERT);
  assign full      = (count == CW'(TABLE_DEPTH));
  assign step      = (state == S_MERGE) && ob_free;
  assign cons_inc  = cons + CW'(1);

  // pick the next element of the merged sequence
  always_comb begin
    take_new = 1'b0;
    take_old = 1'b0;
    finish   = 1'b0;
    if (step) begin
      if (dvalid) begin
        if (!placed && (nreq.start < rd_data.start)) begin
          take_new = 1'b1;
        end else begin
          take_old = 1'b1;
        end
      end else if (!placed) begin
        take_new = 1'b1;
      end else begin
        finish = 1'b1;
      end
    end
    elem  = take_new ? nreq : rd_data;
    close = have_cur && (cur.stop < elem.start);
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = w[AW-1:0];
    wr_data = cur;
    if (acc_ins && !full && (count != '0)) begin
      rd_en = 1'b1;
    end else if (take_old && (cons_inc < count)) begin
      rd_en   = 1'b1;
      rd_addr = cons_inc[AW-1:0];
    end
    if (acc_app && !full) begin
      wr_en      = 1'b1;
      wr_addr    = count[AW-1:0];
      wr_data.start = req.new_start;
      wr_data.stop  = req.new_stop;
    end else if (finish || ((take_new || take_old) && close)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // result load
  always_comb begin
    ob_load      = 1'b0;
    ob_item.start = cur.start;
    ob_item.stop  = cur.stop;
    ob_item.last  = finish;
    ob_item.ovf   = 1'b0;
    if (state == S_OVF) begin
      ob_load       = ob_free;
      ob_item.start = '0;
      ob_item.stop  = '0;
      ob_item.last  = 1'b1;
      ob_item.ovf   = 1'b1;
    end else if (finish || ((take_new || take_old) && close)) begin
      ob_load = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc_ins) begin
          state_next = full ? S_OVF : S_MERGE;
        end
      end
      S_MERGE: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      S_OVF: begin
        if (ob_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      cons     <= '0;
      w        <= '0;
      placed   <= 1'b0;
      have_cur <= 1'b0;
      dvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (acc_app && !full) begin
        count <= count + CW'(1);
      end
      if (acc_ins && !full) begin
        cons     <= '0;
        w        <= '0;
        placed   <= 1'b0;
        have_cur <= 1'b0;
        dvalid   <= (count != '0);
      end
      if (take_new || take_old) begin
        have_cur <= 1'b1;
        if (close) begin
          w <= w + CW'(1);
        end
      end
      if (take_new) begin
        placed <= 1'b1;
      end
      if (take_old) begin
        cons   <= cons_inc;
        dvalid <= (cons_inc < count);
      end
      if (finish) begin
        count <= w + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_ins) begin
      nreq.start <= req.new_start;
      nreq.stop  <= req.new_stop;
    end
    if (take_new || take_old) begin
      if (!have_cur || close) begin
        cur <= elem;
      end else if (cur.stop < elem.stop) begin
        cur.stop <= elem.stop;
      end
    end
  end

  siim_out_buf u_out_buf (
    .clk  (clk),
    .rst  (rst),
    .load (ob_load),
    .item (ob_item),
    .free (ob_free),
    .rsp  (rsp)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_full_insert_ovf: assert property (@(posedge clk) disable iff (rst)
    acc_ins && full |=> state == S_OVF)
    else $error("insert into full table did not flag overflow");

  a_wb_behind_read: assert property (@(posedge clk) disable iff (rst)
    state == S_MERGE && have_cur |-> ({1'b0, w} < ({1'b0, cons} + {{CW{1'b0}}, placed})))
    else $error("write-back index caught up with the read walk");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ob_load |-> ob_free)
    else $error("result loaded over a pending result");

  a_ovf_is_last: assert property (@(posedge clk) disable iff (rst)
    ob_load && ob_item.ovf |-> ob_item.last && state == S_OVF)
    else $error("overflow result without last mark");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sorted_interval_insert_merge_core
// Sends append and insert requests with random gaps on both channels, keeps
// a shadow interval table, predicts the merged table emitted by each insert
// and compares every returned row in order. Random traffic runs in value
// bands that move downward, so the table keeps room to grow and merge. The
// run ends by filling the table and hitting the overflow path.
// ----------------------------------------------------------------------------
module tb_top;
  import siim_pkg::*;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

  logic clk;
  logic rst;

  siim_req_if req_ch();
  siim_rsp_if rsp_ch();

  sorted_interval_insert_merge_core #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // shadow of the interval table
  logic signed [31:0] tab_start [TABLE_DEPTH];
  logic signed [31:0] tab_stop  [TABLE_DEPTH];
  int unsigned        tab_count;

  rsp_t table_rows_due[$];

  int unsigned err_count;
  int unsigned req_count;
  int unsigned insert_count;
  int unsigned rows_checked;
  int unsigned ovf_count;
  int unsigned max_rows;
  bit          req_no_gaps;
  bit          rsp_no_stalls;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Updates the shadow table and queues the rows the request must produce.
  function automatic void predict_table_rows(req_kind_t kind, logic signed [31:0] s,
                                             logic signed [31:0] e);
    logic signed [31:0] ws [TABLE_DEPTH+1];
    logic signed [31:0] we [TABLE_DEPTH+1];
    int unsigned n;
    int unsigned m;
    bit          placed;
    rsp_t        row;
    n = 0;
    placed = 1'b0;
    if (kind == REQ_APPEND) begin
      if (tab_count < TABLE_DEPTH) begin
        tab_start[tab_count] = s;
        tab_stop[tab_count] = e;
        tab_count++;
      end
      return;
    end
    insert_count++;
    if (tab_count >= TABLE_DEPTH) begin
      row.start = '0;
      row.stop = '0;
      row.last = 1'b1;
      row.ovf = 1'b1;
      table_rows_due.push_back(row);
      ovf_count++;
      return;
    end
    for (int i = 0; i < tab_count; i++) begin
      if (!placed && s < tab_start[i]) begin
        ws[n] = s;
        we[n] = e;
        n++;
        placed = 1'b1;
      end
      ws[n] = tab_start[i];
      we[n] = tab_stop[i];
      n++;
    end
    if (!placed) begin
      ws[n] = s;
      we[n] = e;
      n++;
    end
    // single merge pass in table order, no sort
    tab_start[0] = ws[0];
    tab_stop[0] = we[0];
    m = 1;
    for (int i = 1; i < n; i++) begin
      if (tab_stop[m-1] < ws[i]) begin
        tab_start[m] = ws[i];
        tab_stop[m] = we[i];
        m++;
      end else if (tab_stop[m-1] < we[i]) begin
        tab_stop[m-1] = we[i];
      end
    end
    tab_count = m;
    for (int i = 0; i < m; i++) begin
      row.start = tab_start[i];
      row.stop = tab_stop[i];
      row.last = (i + 1 == m);
      row.ovf = 1'b0;
      table_rows_due.push_back(row);
    end
    if (m > max_rows) max_rows = m;
  endfunction

  function automatic int unsigned pick_gap(bit no_gap);
    int unsigned r;
    if (no_gap) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic send_request(req_kind_t kind, logic signed [31:0] s, logic signed [31:0] e);
    int unsigned gap;
    gap = pick_gap(req_no_gaps);
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.new_start <= s;
    req_ch.new_stop <= e;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_table_rows(kind, s, e);
    req_count++;
  endtask

  // sender holds off until every queued row has come back
  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (table_rows_due.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic test_basic_merge();
    send_request(REQ_INSERT, 5, 10);     // insert into empty table
    send_request(REQ_APPEND, 20, 30);
    send_request(REQ_INSERT, 12, 15);
    send_request(REQ_INSERT, 9, 21);     // bridges everything into one
    send_request(REQ_INSERT, 30, 40);    // start equal to running stop
    send_request(REQ_INSERT, 5, 7);      // equal start goes after the stored one
    send_request(REQ_INSERT, 41, 41);    // one above the stop stays separate
  endtask

  task automatic test_signed_order();
    send_request(REQ_INSERT, -20, -10);
    send_request(REQ_INSERT, -1, 3);
    send_request(REQ_INSERT, VMAX, VMAX);
    send_request(REQ_INSERT, VMIN, VMIN);
    send_request(REQ_INSERT, 0, -5);     // stop below start
    send_request(REQ_INSERT, VMAX, VMIN);
  endtask

  task automatic test_unordered_append();
    send_request(REQ_APPEND, 100, 50);
    send_request(REQ_APPEND, -50, -40);  // lower than what precedes it
    send_request(REQ_INSERT, 60, 70);
    send_request(REQ_APPEND, 1000, 2000);
    send_request(REQ_APPEND, 500, 600);
    send_request(REQ_INSERT, 550, 1500);
    drain_results();
  endtask

  // Each band lies below the previous one; a sweep [base, max] at the end of
  // a band folds it into one entry, keeping the space below it free.
  task automatic test_random_bands();
    logic [31:0]        band_ofs;
    logic signed [31:0] base;
    logic signed [31:0] s;
    logic signed [31:0] e;
    int unsigned        span;
    int unsigned        len;
    int unsigned        r;
    req_kind_t          kind;
    for (int ep = 0; ep < 7; ep++) begin
      req_no_gaps = (ep == 2 || ep == 5);
      rsp_no_stalls = (ep == 3 || ep == 5);
      band_ofs = (7 - ep) << 29;
      base = VMIN + band_ofs + $urandom_range(0, 1 << 27);
      case ($urandom_range(0, 3))
        0: span = 32;
        1: span = 256;
        2: span = 65536;
        default: span = 1 << 27;
      endcase
      for (int k = 0; k < 70; k++) begin
        if (tab_count >= TABLE_DEPTH - 1) begin
          send_request(REQ_INSERT, base, VMAX);
        end else begin
          s = base + $urandom_range(0, span - 1);
          len = $urandom_range(0, span / 8);
          r = $urandom_range(0, 99);
          if (r < 10) e = s;
          else if (r < 22) e = s - len;
          else e = s + len;
          kind = ($urandom_range(0, 99) < 35) ? REQ_APPEND : REQ_INSERT;
          send_request(kind, s, e);
        end
      end
      send_request(REQ_INSERT, base, VMAX);
      if (ep % 2 == 1) drain_results();
    end
    req_no_gaps = 1'b0;
    rsp_no_stalls = 1'b0;
  endtask

  // Fills the table with disjoint intervals at the bottom of the range, the
  // last insert emitting a full table, then drives both requests when full.
  task automatic test_full_table();
    logic signed [31:0] s;
    int unsigned        j;
    drain_results();
    j = 0;
    while (tab_count < TABLE_DEPTH && j < 2 * TABLE_DEPTH) begin
      s = VMIN + 32'h0100_0000 - 64 * (j + 1);
      send_request(REQ_INSERT, s, s + 8);
      j++;
    end
    send_request(REQ_APPEND, 77, 88);   // dropped
    send_request(REQ_INSERT, VMIN, VMAX);
    send_request(REQ_INSERT, 3, 4);
    drain_results();
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_no_stalls) begin
        rsp_ch.ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        hold--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]: rsp_ch.ready <= 1'b1;
          [70:92]: begin
            rsp_ch.ready <= 1'b0;
            hold = $urandom_range(0, 2);
          end
          default: begin
            rsp_ch.ready <= 1'b0;
            hold = $urandom_range(9, 29);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (table_rows_due.size() == 0) begin
        err_count++;
        if (err_count < 50)
          $error("unexpected row: out_start %0d out_stop %0d", rsp_ch.out_start,
                 rsp_ch.out_stop);
      end else begin
        want = table_rows_due.pop_front();
        rows_checked++;
        if (rsp_ch.out_start !== want.start) begin
          err_count++;
          if (err_count < 50)
            $error("out_start: expected %0d, got %0d", $signed(want.start),
                   rsp_ch.out_start);
        end
        if (rsp_ch.out_stop !== want.stop) begin
          err_count++;
          if (err_count < 50)
            $error("out_stop: expected %0d, got %0d", $signed(want.stop),
                   rsp_ch.out_stop);
        end
        if (rsp_ch.is_last !== want.last) begin
          err_count++;
          if (err_count < 50)
            $error("is_last: expected %0b, got %0b", want.last, rsp_ch.is_last);
        end
        if (rsp_ch.overflow !== want.ovf) begin
          err_count++;
          if (err_count < 50)
            $error("overflow: expected %0b, got %0b", want.ovf, rsp_ch.overflow);
        end
      end
    end
  end

  initial begin
    #40ms;
    $error("timeout with %0d rows outstanding", table_rows_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    err_count = 0;
    req_count = 0;
    insert_count = 0;
    rows_checked = 0;
    ovf_count = 0;
    max_rows = 0;
    tab_count = 0;
    req_no_gaps = 1'b0;
    rsp_no_stalls = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_APPEND;
    req_ch.new_start = '0;
    req_ch.new_stop = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_merge();
    test_signed_order();
    test_unordered_append();
    test_random_bands();
    test_full_table();

    $display("Sent %0d requests (%0d inserts); checked %0d table rows, %0d of them overflow.",
             req_count, insert_count, rows_checked, ovf_count);
    $display("Largest emitted table: %0d rows; %0d mismatches.", max_rows, err_count);
    if (err_count == 0 && table_rows_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sorted_interval_insert_merge_core.f */
sv/siim_pkg.sv
sv/siim_req_if.sv
sv/siim_rsp_if.sv
sv/siim_out_buf.sv
sv/sorted_interval_insert_merge_core.sv
bench/tb_top.sv
